FILE: rtl/core/swa_pkg.sv
// Shared constants, types and state encoding of the sliding window average unit.
package swa_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LEN_W   = 9;   // window_length register width
  localparam int AVG_W   = 24;  // average width, 16.8 fixed point
  localparam int FRAC_W  = 8;
  localparam int DATA_W  = 32;  // APB data width
  localparam int PADDR_W = 3;

  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } swa_state_e;

  typedef struct packed {
    logic             flush;
    logic [LEN_W-1:0] len;
  } swa_cfg_t;

endpackage

FILE: rtl/core/swa_sample_if.sv
// Input channel carrying one sample per request.
interface swa_sample_if import swa_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/swa_average_if.sv
// Output channel carrying one window average per request.
interface swa_average_if import swa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/core/swa_regs.sv
// APB register file holding the window length and raising a flush on each write to it.
module swa_regs import swa_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output swa_cfg_t           cfg_o
);

  localparam logic [LEN_W-1:0] LenRst = LEN_W'(MAX_WINDOW < 256 ? MAX_WINDOW : 256);

  logic [LEN_W-1:0]     len_q, len_d;
  logic [LEN_W-1:0]     wval;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_WINDOW_LENGTH);
  assign wval    = pwdata[LEN_W-1:0];

  always_comb begin
    len_d = len_q;
    if (wr_en) begin
      if (wval == '0) begin
        len_d = LEN_W'(1);
      end else if (int'(wval) > MAX_WINDOW) begin
        len_d = LEN_W'(MAX_WINDOW);
      end else begin
        len_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenRst;
    end else begin
      len_q <= len_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LENGTH: prdata = DATA_W'(len_q);
      default:           prdata = '0;
    endcase
  end

  // flush acts at the write edge, together with the new length
  assign cfg_o.flush = wr_en;
  assign cfg_o.len   = len_q;

endmodule

FILE: rtl/core/swa_history.sv
// Sample delay line memory with registered read-before-write port.
module swa_history #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/swa_divider.sv
// Restoring divider, one quotient bit per cycle.
module swa_divider #(
  parameter int DIVD_W = 33,
  parameter int DIVS_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] acc_q, acc_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              qbit;

  assign trial = {rem_q, acc_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = !diff[DIVS_W];

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so its low bits are enough
      rem_d = qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      acc_d = {acc_q[DIVD_W-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i && !busy_q) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

FILE: rtl/core/sliding_window_average_unit.sv
// Moving average over the newest window_length samples, 16.8 fixed point result.
// Path from accepted sample to result: sum update, bit-serial division of the
//   SAMPLE_BITS+17 bit dividend, divider done, output load.
// Input: a new sample is taken only in idle, after the division and output load of the last,
//   later while a result waits; samples that complete no window return to idle after the update.
// Reset: asynchronous, active low; window empty, window_length = min(MAX_WINDOW, 256), no memory clear.
module sliding_window_average_unit import swa_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  swa_sample_if.sink         sample_ch_i,
  swa_average_if.source      average_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW     = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int SUM_W  = SAMPLE_BITS + LEN_W;
  localparam int DIVD_W = SUM_W + FRAC_W;

  swa_cfg_t cfg;

  swa_state_e state_q, state_d;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [AW-1:0]          wpos_q, wpos_d;
  logic [LEN_W-1:0]       fill_q, fill_d;
  logic [AW-1:0]          pos_q;
  logic                   full_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [AVG_W-1:0]       avg_q;
  logic                   out_valid_q, out_valid_d;

  logic                   accept;
  logic [AW-1:0]          rd_pos;
  logic [SAMPLE_BITS-1:0] hist_rd;
  logic [AW:0]            pos_inc;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [DIVD_W-1:0]      quotient;
  logic                   out_load;

  swa_regs #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign sample_ch_i.ready = (state_q == ST_IDLE);
  assign accept            = sample_ch_i.valid && sample_ch_i.ready;
  assign rd_pos            = (CW'(wpos_q) >= CW'(cfg.len)) ? '0 : wpos_q;

  swa_history #(
    .DEPTH(MAX_WINDOW),
    .AW   (AW),
    .DW   (SAMPLE_BITS)
  ) u_history (
    .clk_i  (clk_i),
    .en_i   (accept),
    .addr_i (rd_pos),
    .wdata_i(sample_ch_i.sample),
    .rdata_o(hist_rd)
  );

  swa_divider #(
    .DIVD_W(DIVD_W),
    .DIVS_W(LEN_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_d, FRAC_W'(0)}),
    .divisor_i (cfg.len),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign pos_inc = {1'b0, pos_q} + (AW + 1)'(1);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    wpos_d      = wpos_q;
    fill_d      = fill_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    if (average_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // oldest sample leaves only once the window is full
        sum_d  = sum_q - (full_q ? SUM_W'(hist_rd) : SUM_W'(0)) + SUM_W'(sample_q);
        fill_d = full_q ? cfg.len : fill_q + LEN_W'(1);
        wpos_d = (CW'(pos_inc) >= CW'(cfg.len)) ? '0 : pos_inc[AW-1:0];
        if (fill_d == cfg.len) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_valid_q || average_ch_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg.flush) begin
      sum_d  = '0;
      wpos_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      wpos_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q    <= rd_pos;
      full_q   <= (fill_q >= cfg.len);
      sample_q <= sample_ch_i.sample;
    end
    if (out_load) begin
      avg_q <= AVG_W'(quotient);
    end
  end

  assign average_ch_o.valid   = out_valid_q;
  assign average_ch_o.average = avg_q;

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_ch_i.ready |-> !div_busy)
    else $error("input ready while divider busy");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cfg.len)
    else $error("fill count exceeds window length");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(wpos_q) < CW'(cfg.len))
    else $error("write position outside window");

  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_UPDATE)
    else $error("accepted request not followed by update");

  a_divide_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy && state_q == ST_DIVIDE)
    else $error("divider did not start");

endmodule
